@@ design/kcf_pkg.sv @@
package kcf_pkg;

    // Ring geometry. The ring holds at most RING_SLOTS-1 entries.
    localparam int RING_SLOTS = 16;
    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int COUNT_W    = $clog2(RING_SLOTS);

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 4;
    localparam int KCODE_W  = 5;
    localparam int FILL_W   = 4;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [CHAR_W-1:0]  key_char_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [KCODE_W-1:0] key_code_t;
    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam cmd_t CMD_PUSH  = 2'd0;
    localparam cmd_t CMD_PULL  = 2'd1;
    localparam cmd_t CMD_FLUSH = 2'd2;

    // Code returned when there is no key to report.
    localparam key_code_t CODE_NONE = 5'd16;

    localparam slot_t  SLOT_LAST  = SLOT_W'(RING_SLOTS - 1);
    localparam count_t COUNT_FULL = COUNT_W'(RING_SLOTS - 1);

    // Translates a raw keypad character to its code, or CODE_NONE when the
    // character has no mapping.
    function automatic key_code_t translate_char(key_char_t ch);
        key_code_t code;
        unique case (ch)
            8'h31:   code = 5'd0;   // '1'
            8'h43:   code = 5'd1;   // 'C'
            8'h44:   code = 5'd2;   // 'D'
            8'h45:   code = 5'd3;   // 'E'
            8'h38:   code = 5'd4;   // '8'
            8'h39:   code = 5'd5;   // '9'
            8'h41:   code = 5'd6;   // 'A'
            8'h34:   code = 5'd7;   // '4'
            8'h35:   code = 5'd8;   // '5'
            8'h36:   code = 5'd9;   // '6'
            8'h30:   code = 5'd10;  // '0'
            8'h32:   code = 5'd11;  // '2'
            8'h33:   code = 5'd12;  // '3'
            8'h37:   code = 5'd13;  // '7'
            8'h42:   code = 5'd14;  // 'B'
            8'h46:   code = 5'd15;  // 'F'
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic slot_t next_slot(slot_t s);
        slot_t n;
        if (s == SLOT_LAST)
        begin
            n = '0;
        end
        else
        begin
            n = s + slot_t'(1);
        end
        return n;
    endfunction

endpackage

@@ design/kcf_req_if.sv @@
interface kcf_req_if;
    import kcf_pkg::*;

    logic      valid;
    logic      ready;
    cmd_t      command;
    key_char_t key_char;

    modport source (output valid, output command, output key_char, input ready);
    modport sink   (input valid, input command, input key_char, output ready);
endinterface

@@ design/kcf_rsp_if.sv @@
interface kcf_rsp_if;
    import kcf_pkg::*;

    logic      valid;
    logic      ready;
    key_code_t key_code;
    logic      rejected;
    fill_t     fill_count;

    modport source (output valid, output key_code, output rejected, output fill_count,
                    input ready);
    modport sink   (input valid, input key_code, input rejected, input fill_count,
                    output ready);
endinterface

@@ design/kcf_code_ram.sv @@
module kcf_code_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ design/keypad_code_fifo.sv @@
// Push, flush and a pull from an empty ring load their result into the output register
// when they are accepted; a pull that returns a stored code first reads the code memory
// through its registered read port and then loads the code into the output register.
// Throughput: one item per cycle while results are taken at once; a pending memory read
// and a result that the receiver has not taken both hold off the next request.
// Reset (rst_n, asynchronous, active low) empties the ring; the code memory is not cleared.
module keypad_code_fifo (
    input  logic clk,
    input  logic rst_n,
    kcf_req_if.sink   req,
    kcf_rsp_if.source rsp
);
    import kcf_pkg::*;

    // Ring pointers and the number of entries held.
    slot_t  write_slot_reg, write_slot_next;
    slot_t  read_slot_reg,  read_slot_next;
    count_t held_count_reg, held_count_next;

    // Output register. A pull that reads the memory loads the count and the
    // rejected flag when it is accepted and the code in the cycle after.
    logic      out_valid_reg,  out_valid_next;
    logic      pull_wait_reg,  pull_wait_next;
    key_code_t key_code_reg,   key_code_next;
    logic      rejected_reg,   rejected_next;
    fill_t     fill_count_reg, fill_count_next;

    logic      req_fire;
    logic      rsp_fire;
    key_code_t xlate_code;
    logic      mapped;
    logic      ram_wr_en;
    logic      ram_rd_en;
    code_t     ram_rd_data;

    // A new item is taken when no memory read is pending and the output
    // register is free or is being emptied at this edge. A result that the
    // receiver holds off therefore stalls the next request.
    assign req.ready = !pull_wait_reg && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = out_valid_reg && rsp.ready;

    assign xlate_code = translate_char(req.key_char);
    assign mapped     = (xlate_code != CODE_NONE);

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        held_count_next = held_count_reg;
        out_valid_next  = out_valid_reg;
        pull_wait_next  = pull_wait_reg;
        key_code_next   = key_code_reg;
        rejected_next   = rejected_reg;
        fill_count_next = fill_count_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;

        if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (pull_wait_reg)
        begin
            // The stored code has come out of the memory.
            key_code_next  = {1'b0, ram_rd_data};
            out_valid_next = 1'b1;
            pull_wait_next = 1'b0;
        end
        else if (req_fire)
        begin
            key_code_next  = CODE_NONE;
            rejected_next  = 1'b0;
            out_valid_next = 1'b1;
            unique case (req.command)
                CMD_PUSH:
                begin
                    if (mapped && (held_count_reg != COUNT_FULL))
                    begin
                        ram_wr_en       = 1'b1;
                        write_slot_next = next_slot(write_slot_reg);
                        held_count_next = held_count_reg + count_t'(1);
                    end
                    else
                    begin
                        rejected_next = 1'b1;
                    end
                end
                CMD_PULL:
                begin
                    if (held_count_reg != '0)
                    begin
                        // Read the oldest entry; the result waits for the registered memory read.
                        ram_rd_en       = 1'b1;
                        read_slot_next  = next_slot(read_slot_reg);
                        held_count_next = held_count_reg - count_t'(1);
                        out_valid_next  = 1'b0;
                        pull_wait_next  = 1'b1;
                    end
                end
                CMD_FLUSH:
                begin
                    write_slot_next = '0;
                    read_slot_next  = '0;
                    held_count_next = '0;
                end
                default:
                begin
                    // The unused command leaves the ring as it is.
                end
            endcase
            fill_count_next = FILL_W'(held_count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            pull_wait_reg  <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            held_count_reg <= held_count_next;
            out_valid_reg  <= out_valid_next;
            pull_wait_reg  <= pull_wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_code_reg   <= key_code_next;
        rejected_reg   <= rejected_next;
        fill_count_reg <= fill_count_next;
    end

    kcf_code_ram #(
        .DEPTH (RING_SLOTS),
        .WIDTH (CODE_W)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (xlate_code[CODE_W-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (read_slot_reg),
        .rd_data (ram_rd_data)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.key_code   = key_code_reg;
    assign rsp.rejected   = rejected_reg;
    assign rsp.fill_count = fill_count_reg;
endmodule

@@ tb/kcf_result_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the keypad code FIFO. It keeps its own copy of the
// ring, works out the result of every accepted request, and compares each
// accepted result with the oldest one still awaited.
module kcf_result_checker (
    input  logic clk,
    input  logic rst_n,
    kcf_req_if   req,
    kcf_rsp_if   rsp,
    output int   fail_count,
    output int   results_owed,
    output int   stored_pushes,
    output int   refused_pushes,
    output int   full_refusals,
    output int   codes_pulled,
    output int   empty_pulls,
    output int   flushes,
    output int   unused_cmds,
    output int   deepest_fill
);
    import kcf_pkg::*;

    typedef struct {
        key_code_t key_code;
        logic      rejected;
        fill_t     fill_count;
    } kcf_result_t;

    // Keypad characters in code order: the character at position n maps to code n.
    localparam bit [0:15][7:0] KEY_ORDER = "1CDE89A4560237BF";

    code_t  ring_codes [RING_SLOTS];
    slot_t  head_slot;
    slot_t  tail_slot;
    count_t ring_depth;

    kcf_result_t awaited_results [$];

    function automatic key_code_t keypad_lookup(key_char_t ch);
        key_code_t code;
        code = CODE_NONE;
        for (int i = 0; i < 16; i++)
        begin
            if (KEY_ORDER[i] == ch)
            begin
                code = key_code_t'(i);
            end
        end
        return code;
    endfunction

    function automatic slot_t advance_slot(slot_t s);
        return (int'(s) == RING_SLOTS - 1) ? slot_t'(0) : slot_t'(s + 1'b1);
    endfunction

    task automatic report_fault(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Applies one request to the ring copy and queues the result it must give.
    task automatic apply_keypad_request(input cmd_t cmd, input key_char_t ch);
        kcf_result_t res;
        key_code_t   code;
        res.key_code = CODE_NONE;
        res.rejected = 1'b0;
        case (cmd)
            CMD_PUSH:
            begin
                code = keypad_lookup(ch);
                if (code == CODE_NONE || ring_depth >= COUNT_FULL)
                begin
                    res.rejected = 1'b1;
                    refused_pushes++;
                    if (code != CODE_NONE)
                    begin
                        full_refusals++;
                    end
                end
                else
                begin
                    ring_codes[head_slot] = code_t'(code);
                    head_slot = advance_slot(head_slot);
                    ring_depth++;
                    stored_pushes++;
                end
            end
            CMD_PULL:
            begin
                if (ring_depth != 0)
                begin
                    res.key_code = key_code_t'(ring_codes[tail_slot]);
                    tail_slot = advance_slot(tail_slot);
                    ring_depth--;
                    codes_pulled++;
                end
                else
                begin
                    empty_pulls++;
                end
            end
            CMD_FLUSH:
            begin
                head_slot  = '0;
                tail_slot  = '0;
                ring_depth = '0;
                flushes++;
            end
            default:
            begin
                unused_cmds++;
            end
        endcase
        res.fill_count = fill_t'(ring_depth);
        if (int'(ring_depth) > deepest_fill)
        begin
            deepest_fill = int'(ring_depth);
        end
        awaited_results.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kcf_result_t want;
        if (!rst_n)
        begin
            head_slot      = '0;
            tail_slot      = '0;
            ring_depth     = '0;
            fail_count     = 0;
            stored_pushes  = 0;
            refused_pushes = 0;
            full_refusals  = 0;
            codes_pulled   = 0;
            empty_pulls    = 0;
            flushes        = 0;
            unused_cmds    = 0;
            deepest_fill   = 0;
            awaited_results.delete();
        end
        else
        begin
            // Results first: a request accepted at this edge cannot answer at it.
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_fault($sformatf("unexpected result: code %0d rej %0b fill %0d",
                                           rsp.key_code, rsp.rejected, rsp.fill_count));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.key_code !== want.key_code)
                    begin
                        report_fault($sformatf("key_code got %0d want %0d",
                                               rsp.key_code, want.key_code));
                    end
                    if (rsp.rejected !== want.rejected)
                    begin
                        report_fault($sformatf("rejected got %0b want %0b",
                                               rsp.rejected, want.rejected));
                    end
                    if (rsp.fill_count !== want.fill_count)
                    begin
                        report_fault($sformatf("fill_count got %0d want %0d",
                                               rsp.fill_count, want.fill_count));
                    end
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                apply_keypad_request(req.command, req.key_char);
            end
        end
        results_owed = awaited_results.size();
    end

endmodule

@@ tb/tb_keypad_code_fifo.sv @@
`timescale 1ns / 100ps

// Top of the keypad code FIFO testbench. This module only produces stimulus
// and gives the verdict; prediction and comparison live in the checker.
module tb_keypad_code_fifo;
    import kcf_pkg::*;

    // The fourth command encoding has no meaning; the block must ignore it.
    localparam cmd_t CMD_IGNORED = 2'd3;

    // Cycles without any accepted item before the run is declared hung. The
    // longest legal quiet stretch is the long receiver hold-off below.
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_STALL = 90;

    logic clk;
    logic rst_n;

    kcf_req_if req_ch ();
    kcf_rsp_if rsp_ch ();

    int fail_count;
    int results_owed;
    int stored_pushes;
    int refused_pushes;
    int full_refusals;
    int codes_pulled;
    int empty_pulls;
    int flushes;
    int unused_cmds;
    int deepest_fill;

    int items_sent;
    int push_bias;
    int stall_requests;
    int stalls_served;
    int idle_cycles;

    keypad_code_fifo dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    kcf_result_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .fail_count     (fail_count),
        .results_owed   (results_owed),
        .stored_pushes  (stored_pushes),
        .refused_pushes (refused_pushes),
        .full_refusals  (full_refusals),
        .codes_pulled   (codes_pulled),
        .empty_pulls    (empty_pulls),
        .flushes        (flushes),
        .unused_cmds    (unused_cmds),
        .deepest_fill   (deepest_fill)
    );

    // 12 ns clock: six nanoseconds low, six high.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hex digits are exactly the characters with a mapping, so the stimulus
    // picks mapped characters through this rather than through a table.
    function automatic key_char_t hex_char(int i);
        return (i < 10) ? key_char_t'(8'h30 + i) : key_char_t'(8'h41 + i - 10);
    endfunction

    // Offers one item at the falling edge and holds it until the block takes
    // it at a rising edge. Valid is never lowered between back-to-back items.
    task automatic offer_item(input cmd_t cmd, input key_char_t ch);
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.command  <= cmd;
        req_ch.key_char <= ch;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // Leaves the request channel idle with junk on the payload lines.
    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid    <= 1'b0;
            req_ch.command  <= cmd_t'($urandom);
            req_ch.key_char <= key_char_t'($urandom);
        end
    endtask

    // Draws one request. The push bias drifts between sections so that the
    // ring is driven both to full and to empty, where the special cases sit.
    task automatic random_request(output cmd_t cmd, output key_char_t ch);
        int roll;
        roll = $urandom_range(0, 99);
        ch   = key_char_t'($urandom);
        if (roll < 2)
        begin
            cmd = CMD_IGNORED;
        end
        else if (roll < 5)
        begin
            cmd = CMD_FLUSH;
        end
        else if ($urandom_range(0, 99) < push_bias)
        begin
            cmd = CMD_PUSH;
            // Most pushes carry a valid key; the rest are arbitrary bytes.
            if ($urandom_range(0, 99) < 85)
            begin
                ch = hex_char($urandom_range(0, 15));
            end
        end
        else
        begin
            cmd = CMD_PULL;
        end
    endtask

    // Sends random requests in bursts of random length. Some gaps are zero,
    // so long stretches run without any idling on the request side.
    task automatic run_random(input int count);
        int        sent;
        int        burst;
        cmd_t      cmd;
        key_char_t ch;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                if (sent % 40 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       push_bias = 15;
                        1:       push_bias = 50;
                        default: push_bias = 85;
                    endcase
                end
                random_request(cmd, ch);
                offer_item(cmd, ch);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                hold_off($urandom_range(1, 6));
            end
        end
    endtask

    // Receiver: readiness follows a pattern that is drawn anew at random intervals
    // (always ready, coin flip, mostly stalled, periodic). A request
    // from the stimulus side starts a long hold-off, counted here.
    initial
    begin
        int   mode;
        int   mode_left;
        int   hold_left;
        int   phase;
        logic next_ready;
        mode           = 0;
        mode_left      = 0;
        hold_left      = 0;
        phase          = 0;
        stalls_served  = 0;
        rsp_ch.ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stalls_served != stall_requests)
            begin
                stalls_served = stall_requests;
                hold_left     = LONG_STALL;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 64);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       next_ready = 1'b1;
                    1:       next_ready = 1'($urandom_range(0, 1));
                    2:       next_ready = ($urandom_range(0, 3) == 0);
                    default: next_ready = (phase % 3 == 0);
                endcase
            end
            rsp_ch.ready <= next_ready;
        end
    end

    // Watchdog: a run that stops moving items on both channels is hung.
    always @(posedge clk)
    begin
        if (rst_n && !(req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no item accepted for %0d cycles, %0d results owed",
                         IDLE_LIMIT, results_owed);
                $display("CHECK FAILED");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.command  = CMD_PUSH;
        req_ch.key_char = '0;
        rst_n           = 1'b0;
        items_sent      = 0;
        push_bias       = 50;
        stall_requests  = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening. An empty pull and the unused command come first,
        // then pushes of the two byte extremes, which have no mapping.
        offer_item(CMD_PULL, 8'h00);
        offer_item(CMD_IGNORED, 8'hFF);
        offer_item(CMD_PUSH, 8'h00);
        offer_item(CMD_PUSH, 8'hFF);
        // Fifteen valid keys fill the ring; the sixteenth must be refused.
        for (int i = 0; i < 15; i++)
        begin
            offer_item(CMD_PUSH, hex_char(i));
        end
        offer_item(CMD_PUSH, hex_char(15));
        // The unused command on a full ring reports the count untouched.
        offer_item(CMD_IGNORED, 8'h00);
        offer_item(CMD_PULL, 8'hFF);
        // A flush drops everything, so the pull after it finds nothing.
        offer_item(CMD_FLUSH, 8'hA5);
        offer_item(CMD_PULL, 8'h5A);

        run_random(230);

        // Long receiver hold-off while pushes keep coming: the ring fills,
        // pushes are refused, and the result side backs up into the input.
        stall_requests++;
        for (int i = 0; i < 40; i++)
        begin
            offer_item(CMD_PUSH, hex_char($urandom_range(0, 15)));
        end

        run_random(230);

        // Pause with nothing in flight before carrying on.
        hold_off(1);
        wait (results_owed == 0);
        hold_off($urandom_range(1, 4));

        run_random(230);

        // Drain: every awaited result must arrive, then the bench waits on to
        // make sure nothing extra comes out. The watchdog bounds the wait.
        hold_off(1);
        wait (results_owed == 0);
        repeat (8) @(posedge clk);

        $display("Run covered %0d requests: %0d keys stored, %0d pushes refused",
                 items_sent, stored_pushes, refused_pushes);
        $display("(%0d on a full ring), %0d codes pulled, %0d empty pulls, %0d flushes,",
                 full_refusals, codes_pulled, empty_pulls, flushes);
        $display("%0d unused commands, deepest fill %0d.", unused_cmds, deepest_fill);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/kcf_pkg.sv
design/kcf_req_if.sv
design/kcf_rsp_if.sv
design/kcf_code_ram.sv
design/keypad_code_fifo.sv
tb/kcf_result_checker.sv
tb/tb_keypad_code_fifo.sv
